/* design/ucrh_pkg.sv */
package ucrh_pkg;

  // number of endpoints that carry a halt bit
  localparam int NUM_ENDPOINTS = 16;

  // response status codes
  localparam logic [1:0] STATUS_ACK   = 2'd0;
  localparam logic [1:0] STATUS_STALL = 2'd1;
  localparam logic [1:0] STATUS_FWD   = 2'd2;

  // raised event codes
  localparam logic [1:0] EVENT_NONE      = 2'd0;
  localparam logic [1:0] EVENT_ADDRESSED = 2'd1;
  localparam logic [1:0] EVENT_CONFIGURED = 2'd2;
  localparam logic [1:0] EVENT_INTF_SET  = 2'd3;

  // device states reported by the bus layer
  localparam logic [2:0] DEV_CREATED    = 3'd0;
  localparam logic [2:0] DEV_ATTACHED   = 3'd1;
  localparam logic [2:0] DEV_POWERED    = 3'd2;
  localparam logic [2:0] DEV_INIT       = 3'd3;
  localparam logic [2:0] DEV_DEFAULT    = 3'd4;
  localparam logic [2:0] DEV_ADDRESSED  = 3'd5;
  localparam logic [2:0] DEV_CONFIGURED = 3'd6;
  localparam logic [2:0] DEV_UNKNOWN    = 3'd7;

  // standard request codes
  localparam logic [7:0] REQ_GET_STATUS     = 8'd0;
  localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'd1;
  localparam logic [7:0] REQ_SET_FEATURE    = 8'd3;
  localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
  localparam logic [7:0] REQ_SET_DESCRIPTOR = 8'd7;
  localparam logic [7:0] REQ_GET_CONFIG     = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIG     = 8'd9;
  localparam logic [7:0] REQ_GET_INTERFACE  = 8'd10;
  localparam logic [7:0] REQ_SET_INTERFACE  = 8'd11;
  localparam logic [7:0] REQ_SYNCH_FRAME    = 8'd12;

  // recipients
  localparam logic [4:0] RCP_DEVICE    = 5'd0;
  localparam logic [4:0] RCP_INTERFACE = 5'd1;
  localparam logic [4:0] RCP_ENDPOINT  = 5'd2;
  localparam logic [4:0] RCP_OTHER     = 5'd3;

  // request type field
  localparam logic [1:0] TYPE_STANDARD = 2'd0;

  // register addresses
  localparam logic [2:0] ADDR_SELF_POWERED = 3'd0;

  localparam logic [15:0] ADDRESS_MAX = 16'h007f;

  typedef struct packed {
    logic [2:0]  bus_state;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] value_word;
    logic [15:0] index_word;
    logic [15:0] length_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  reply_length;
    logic [7:0]  reply_byte0;
    logic [7:0]  reply_byte1;
    logic [1:0]  raised_event;
    logic [6:0]  device_address;
    logic [6:0]  active_configuration;
    logic [7:0]  active_interface;
    logic [7:0]  active_alternate;
    logic [7:0]  desc_type;
    logic [7:0]  descriptor_index;
    logic [15:0] descriptor_max_length;
  } out_item_t;

  typedef struct packed {
    logic [6:0]               address;
    logic [6:0]               configuration;
    logic [7:0]               intf;
    logic [7:0]               alternate;
    logic [NUM_ENDPOINTS-1:0] halted;
  } dev_regs_t;

endpackage

/* design/ucrh_decode.sv */
module ucrh_decode (
  input  ucrh_pkg::in_item_t  item,
  input  ucrh_pkg::dev_regs_t regs,
  input  logic                self_powered,
  output ucrh_pkg::out_item_t result,
  output ucrh_pkg::dev_regs_t regs_next
);

  logic [4:0] recip;
  logic [3:0] ep;
  logic       ep_halted;
  logic       state_dead;
  logic       state_early;
  logic       early_blocked;
  logic [1:0] status;
  logic [1:0] rlen;
  logic [7:0] b0;
  logic [1:0] ev;
  logic       halt_write;
  logic       halt_value;

  assign recip = item.request_type[4:0];
  assign ep    = item.index_word[3:0];

  // halt bit of the addressed endpoint, unknown endpoints read as clear
  always_comb begin
    ep_halted = 1'b0;
    for (int i = 0; i < ucrh_pkg::NUM_ENDPOINTS; i++) begin
      if (ep == 4'(i)) ep_halted = ep_halted | regs.halted[i];
    end
  end

  // device states that refuse requests
  assign state_dead  = (item.bus_state == ucrh_pkg::DEV_CREATED)
                    || (item.bus_state == ucrh_pkg::DEV_ATTACHED)
                    || (item.bus_state == ucrh_pkg::DEV_POWERED)
                    || (item.bus_state == ucrh_pkg::DEV_UNKNOWN);
  assign state_early = (item.bus_state == ucrh_pkg::DEV_INIT)
                    || (item.bus_state == ucrh_pkg::DEV_DEFAULT);
  assign early_blocked = (item.request_code == ucrh_pkg::REQ_GET_STATUS)
                      || (item.request_code == ucrh_pkg::REQ_CLEAR_FEATURE)
                      || (item.request_code == ucrh_pkg::REQ_SET_FEATURE)
                      || (item.request_code == ucrh_pkg::REQ_SET_DESCRIPTOR)
                      || (item.request_code == ucrh_pkg::REQ_GET_INTERFACE)
                      || (item.request_code == ucrh_pkg::REQ_SET_INTERFACE)
                      || (item.request_code == ucrh_pkg::REQ_SYNCH_FRAME);

  // request decode and state update
  always_comb begin
    status     = ucrh_pkg::STATUS_STALL;
    rlen       = 2'd0;
    b0         = 8'd0;
    ev         = ucrh_pkg::EVENT_NONE;
    halt_write = 1'b0;
    halt_value = 1'b0;
    regs_next  = regs;
    result.desc_type             = 8'd0;
    result.descriptor_index      = 8'd0;
    result.descriptor_max_length = 16'd0;

    priority if (item.request_type[6:5] != ucrh_pkg::TYPE_STANDARD) begin
      status = ucrh_pkg::STATUS_ACK;
    end else if (state_dead || (state_early && early_blocked)) begin
      status = ucrh_pkg::STATUS_STALL;
    end else if (item.request_type[7]) begin
      // device to host
      unique case (item.request_code)
        ucrh_pkg::REQ_GET_STATUS: begin
          status = ucrh_pkg::STATUS_ACK;
          rlen   = 2'd2;
          priority if (recip == ucrh_pkg::RCP_DEVICE) begin
            b0 = {7'd0, self_powered};
          end else if (recip == ucrh_pkg::RCP_ENDPOINT) begin
            b0 = {7'd0, ep_halted};
          end else if (recip == ucrh_pkg::RCP_OTHER) begin
            rlen = 2'd0;
          end else begin
            b0 = 8'd0;
          end
        end
        ucrh_pkg::REQ_GET_DESCRIPTOR: begin
          status = ucrh_pkg::STATUS_FWD;
          result.desc_type             = item.value_word[15:8];
          result.descriptor_index      = item.value_word[7:0];
          result.descriptor_max_length = item.length_word;
        end
        ucrh_pkg::REQ_GET_CONFIG: begin
          status = ucrh_pkg::STATUS_ACK;
          rlen   = 2'd1;
          b0     = {1'b0, regs.configuration};
        end
        ucrh_pkg::REQ_GET_INTERFACE: begin
          status = ucrh_pkg::STATUS_ACK;
          rlen   = 2'd1;
          b0     = regs.alternate;
        end
        default: begin
          status = ucrh_pkg::STATUS_STALL;
        end
      endcase
    end else begin
      // host to device
      unique case (item.request_code)
        ucrh_pkg::REQ_CLEAR_FEATURE, ucrh_pkg::REQ_SET_FEATURE: begin
          if (recip == ucrh_pkg::RCP_ENDPOINT && item.value_word == 16'd0) begin
            status     = ucrh_pkg::STATUS_ACK;
            halt_write = 1'b1;
            halt_value = (item.request_code == ucrh_pkg::REQ_SET_FEATURE);
          end
        end
        ucrh_pkg::REQ_SET_ADDRESS: begin
          if (item.bus_state == ucrh_pkg::DEV_DEFAULT
              && item.value_word <= ucrh_pkg::ADDRESS_MAX) begin
            regs_next.address = item.value_word[6:0];
            status = ucrh_pkg::STATUS_ACK;
            ev     = ucrh_pkg::EVENT_ADDRESSED;
          end
        end
        ucrh_pkg::REQ_SET_CONFIG: begin
          regs_next.configuration = item.value_word[6:0];
          regs_next.intf          = 8'd0;
          regs_next.alternate     = 8'd0;
          status = ucrh_pkg::STATUS_ACK;
          ev     = ucrh_pkg::EVENT_CONFIGURED;
        end
        ucrh_pkg::REQ_SET_INTERFACE: begin
          regs_next.intf      = item.index_word[7:0];
          regs_next.alternate = item.value_word[7:0];
          status = ucrh_pkg::STATUS_ACK;
          ev     = ucrh_pkg::EVENT_INTF_SET;
        end
        default: begin
          status = ucrh_pkg::STATUS_STALL;
        end
      endcase
    end

    // endpoint halt update, endpoints beyond the table change nothing
    for (int i = 0; i < ucrh_pkg::NUM_ENDPOINTS; i++) begin
      if (halt_write && ep == 4'(i)) regs_next.halted[i] = halt_value;
    end

    result.status               = status;
    result.reply_length         = rlen;
    result.reply_byte0          = (rlen == 2'd0) ? 8'd0 : b0;
    result.reply_byte1          = 8'd0;
    result.raised_event         = ev;
    result.device_address       = regs_next.address;
    result.active_configuration = regs_next.configuration;
    result.active_interface     = regs_next.intf;
    result.active_alternate     = regs_next.alternate;
  end

endmodule

/* design/ucrh_apb.sv */
module ucrh_apb (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        self_powered
);

  logic write_en;

  assign pready   = 1'b1;
  assign write_en = psel && penable && pwrite && (paddr == ucrh_pkg::ADDR_SELF_POWERED);

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      self_powered <= 1'b1;
    end else if (write_en) begin
      self_powered <= pwdata[0];
    end
  end

  // register read
  assign prdata = (paddr == ucrh_pkg::ADDR_SELF_POWERED) ? {31'd0, self_powered} : 32'd0;

endmodule

/* design/usb_control_request_handler.sv */
// USB standard control request handler for the SETUP stage of endpoint zero.
// Each transaction on the input channel carries one setup packet and the
// device state from the bus layer; each produces exactly one result with the
// status (ack, stall or forward to the descriptor unit), up to two reply bytes,
// an event code and the stored address, configuration, interface and alternate
// after the request. The block takes one request per cycle unless the result
// side stalls: a request waits in the input register, is decoded against the
// stored state in combinational logic and lands in the result register, which
// also parts the two sides so a new request is taken while a result waits.
// A request passes the input register, its result the result register; a held
// result stalls the input only once the input register is also full. The
// self_powered bit sits at byte address 0 of the APB port and resets to 1.
module usb_control_request_handler (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ucrh_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ucrh_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic                s1_valid;
  ucrh_pkg::in_item_t  s1_item;
  logic                s1_fire;
  ucrh_pkg::dev_regs_t regs;
  ucrh_pkg::dev_regs_t regs_next;
  ucrh_pkg::out_item_t result;
  logic                self_powered;

  // configuration register
  ucrh_apb u_apb (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .self_powered (self_powered)
  );

  // request decode
  ucrh_decode u_decode (
    .item         (s1_item),
    .regs         (regs),
    .self_powered (self_powered),
    .result       (result),
    .regs_next    (regs_next)
  );

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1_item <= in_data;
  end

  // stored device state
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (s1_fire) begin
      regs <= regs_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) out_data <= result;
  end

endmodule

/* tb/sv/tb_usb_control_request_handler.sv */
`timescale 1ns / 100ps

module tb_usb_control_request_handler;

  // one row of the directed script: a setup packet and, where it is obvious,
  // the reply typed in by hand
  typedef struct {
    ucrh_pkg::in_item_t  rq;
    bit                  typed;
    ucrh_pkg::out_item_t want;
  } script_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  ucrh_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ucrh_pkg::out_item_t out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // device model: stored control state and the status register
  logic [6:0]  dev_address;
  logic [6:0]  dev_config;
  logic [7:0]  dev_intf;
  logic [7:0]  dev_alt;
  logic [15:0] ep_halted;
  logic        self_pwr;

  ucrh_pkg::out_item_t pending_replies[$];
  script_row_t         script_rows[$];
  int          field_mismatches = 0;
  int          protocol_errors = 0;
  int          requests_sent = 0;
  int          replies_checked = 0;
  int          acks_seen = 0;
  int          stalls_seen = 0;
  int          forwards_seen = 0;
  int          sink_mode = 0;
  int          sink_tick = 0;
  bit          hold_off_req = 1'b0;

  usb_control_request_handler DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 100 MHz clock
  initial begin
    forever #5 clk = ~clk;
  end

  // hard limit on the run
  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // work out the reply to one setup packet and update the device model
  function automatic ucrh_pkg::out_item_t predict_reply(ucrh_pkg::in_item_t rq);
    ucrh_pkg::out_item_t r;
    logic [4:0] rcp;
    logic [3:0] ep;
    logic       ep_ok;
    logic       blocked;
    r = '0;
    r.status = ucrh_pkg::STATUS_STALL;
    rcp = rq.request_type[4:0];
    ep = rq.index_word[3:0];
    ep_ok = int'(ep) < ucrh_pkg::NUM_ENDPOINTS;
    blocked = 1'b0;
    case (rq.bus_state)
      ucrh_pkg::DEV_CREATED, ucrh_pkg::DEV_ATTACHED, ucrh_pkg::DEV_POWERED,
      ucrh_pkg::DEV_UNKNOWN: begin
        blocked = 1'b1;
      end
      ucrh_pkg::DEV_INIT, ucrh_pkg::DEV_DEFAULT: begin
        case (rq.request_code)
          ucrh_pkg::REQ_GET_STATUS, ucrh_pkg::REQ_CLEAR_FEATURE, ucrh_pkg::REQ_SET_FEATURE,
          ucrh_pkg::REQ_SET_DESCRIPTOR, ucrh_pkg::REQ_GET_INTERFACE,
          ucrh_pkg::REQ_SET_INTERFACE, ucrh_pkg::REQ_SYNCH_FRAME: blocked = 1'b1;
          default: ;
        endcase
      end
      default: ;
    endcase
    if (rq.request_type[6:5] != ucrh_pkg::TYPE_STANDARD) begin
      // class and vendor requests are acked without data
      r.status = ucrh_pkg::STATUS_ACK;
    end else if (!blocked && rq.request_type[7]) begin
      // device to host requests
      case (rq.request_code)
        ucrh_pkg::REQ_GET_STATUS: begin
          r.status = ucrh_pkg::STATUS_ACK;
          r.reply_length = 2'd2;
          if (rcp == ucrh_pkg::RCP_DEVICE) r.reply_byte0 = {7'd0, self_pwr};
          else if (rcp == ucrh_pkg::RCP_ENDPOINT)
            r.reply_byte0 = {7'd0, ep_ok && ep_halted[ep]};
          else if (rcp == ucrh_pkg::RCP_OTHER) r.reply_length = 2'd0;
        end
        ucrh_pkg::REQ_GET_DESCRIPTOR: begin
          r.status = ucrh_pkg::STATUS_FWD;
          r.desc_type = rq.value_word[15:8];
          r.descriptor_index = rq.value_word[7:0];
          r.descriptor_max_length = rq.length_word;
        end
        ucrh_pkg::REQ_GET_CONFIG: begin
          r.status = ucrh_pkg::STATUS_ACK;
          r.reply_length = 2'd1;
          r.reply_byte0 = {1'b0, dev_config};
        end
        ucrh_pkg::REQ_GET_INTERFACE: begin
          r.status = ucrh_pkg::STATUS_ACK;
          r.reply_length = 2'd1;
          r.reply_byte0 = dev_alt;
        end
        default: ;
      endcase
    end else if (!blocked) begin
      // host to device requests
      case (rq.request_code)
        ucrh_pkg::REQ_CLEAR_FEATURE, ucrh_pkg::REQ_SET_FEATURE: begin
          if (rcp == ucrh_pkg::RCP_ENDPOINT && rq.value_word == 16'd0) begin
            r.status = ucrh_pkg::STATUS_ACK;
            if (ep_ok) ep_halted[ep] = (rq.request_code == ucrh_pkg::REQ_SET_FEATURE);
          end
        end
        ucrh_pkg::REQ_SET_ADDRESS: begin
          if (rq.bus_state == ucrh_pkg::DEV_DEFAULT
              && rq.value_word <= ucrh_pkg::ADDRESS_MAX) begin
            dev_address = rq.value_word[6:0];
            r.status = ucrh_pkg::STATUS_ACK;
            r.raised_event = ucrh_pkg::EVENT_ADDRESSED;
          end
        end
        ucrh_pkg::REQ_SET_CONFIG: begin
          dev_config = rq.value_word[6:0];
          dev_intf = 8'd0;
          dev_alt = 8'd0;
          r.status = ucrh_pkg::STATUS_ACK;
          r.raised_event = ucrh_pkg::EVENT_CONFIGURED;
        end
        ucrh_pkg::REQ_SET_INTERFACE: begin
          dev_intf = rq.index_word[7:0];
          dev_alt = rq.value_word[7:0];
          r.status = ucrh_pkg::STATUS_ACK;
          r.raised_event = ucrh_pkg::EVENT_INTF_SET;
        end
        default: ;
      endcase
    end
    if (r.reply_length == 2'd0) r.reply_byte0 = 8'd0;
    r.reply_byte1 = 8'd0;
    r.device_address = dev_address;
    r.active_configuration = dev_config;
    r.active_interface = dev_intf;
    r.active_alternate = dev_alt;
    return r;
  endfunction

  function automatic ucrh_pkg::in_item_t setup_of(logic [2:0] st, logic [7:0] rtype,
                                                  logic [7:0] code, logic [15:0] val,
                                                  logic [15:0] idx, logic [15:0] len);
    ucrh_pkg::in_item_t rq;
    rq.bus_state = st;
    rq.request_type = rtype;
    rq.request_code = code;
    rq.value_word = val;
    rq.index_word = idx;
    rq.length_word = len;
    return rq;
  endfunction

  // reply with the stored state still at its reset value
  function automatic ucrh_pkg::out_item_t reply_of(logic [1:0] st, logic [1:0] rlen,
                                                   logic [7:0] b0);
    ucrh_pkg::out_item_t r;
    r = '0;
    r.status = st;
    r.reply_length = rlen;
    r.reply_byte0 = b0;
    return r;
  endfunction

  // random setup packet: mostly well-formed standard requests, some noise
  function automatic ucrh_pkg::in_item_t rand_setup();
    ucrh_pkg::in_item_t rq;
    logic [7:0] code;
    logic [4:0] rcp;
    logic       dir;
    int         pick;
    pick = $urandom_range(0, 99);
    rq.value_word = 16'($urandom);
    rq.index_word = 16'($urandom);
    rq.length_word = 16'($urandom);
    rq.bus_state = 3'($urandom_range(3, 6));
    if (pick < 70) begin
      case ($urandom_range(0, 10))
        0: code = ucrh_pkg::REQ_GET_STATUS;
        1: code = ucrh_pkg::REQ_CLEAR_FEATURE;
        2: code = ucrh_pkg::REQ_SET_FEATURE;
        3: code = ucrh_pkg::REQ_SET_ADDRESS;
        4: code = ucrh_pkg::REQ_GET_DESCRIPTOR;
        5: code = ucrh_pkg::REQ_SET_DESCRIPTOR;
        6: code = ucrh_pkg::REQ_GET_CONFIG;
        7: code = ucrh_pkg::REQ_SET_CONFIG;
        8: code = ucrh_pkg::REQ_GET_INTERFACE;
        9: code = ucrh_pkg::REQ_SET_INTERFACE;
        default: code = ucrh_pkg::REQ_SYNCH_FRAME;
      endcase
      dir = (code == ucrh_pkg::REQ_GET_STATUS || code == ucrh_pkg::REQ_GET_DESCRIPTOR ||
             code == ucrh_pkg::REQ_GET_CONFIG || code == ucrh_pkg::REQ_GET_INTERFACE ||
             code == ucrh_pkg::REQ_SYNCH_FRAME);
      if ($urandom_range(0, 19) == 0) dir = ~dir;
      rcp = 5'($urandom_range(0, 3));
      if (code == ucrh_pkg::REQ_CLEAR_FEATURE || code == ucrh_pkg::REQ_SET_FEATURE) begin
        rcp = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                          : ucrh_pkg::RCP_ENDPOINT;
        if ($urandom_range(0, 4) != 0) rq.value_word = 16'd0;
      end else if (code == ucrh_pkg::REQ_GET_STATUS) begin
        case ($urandom_range(0, 5))
          4: rcp = 5'($urandom_range(4, 31));
          5: rcp = ucrh_pkg::RCP_ENDPOINT;
          default: ;
        endcase
      end else if (code == ucrh_pkg::REQ_SET_ADDRESS) begin
        if ($urandom_range(0, 9) < 7) rq.bus_state = ucrh_pkg::DEV_DEFAULT;
        if ($urandom_range(0, 4) != 0) rq.value_word = 16'($urandom_range(0, 127));
      end
      rq.request_type = {dir, ucrh_pkg::TYPE_STANDARD, rcp};
      rq.request_code = code;
    end else if (pick < 85) begin
      rq.bus_state = 3'($urandom_range(0, 7));
      rq.request_type = 8'($urandom);
      if (rq.request_type[6:5] == ucrh_pkg::TYPE_STANDARD) rq.request_type[5] = 1'b1;
      rq.request_code = 8'($urandom);
    end else begin
      rq.bus_state = 3'($urandom_range(0, 7));
      rq.request_type = 8'($urandom);
      rq.request_code = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15))
                                                    : 8'($urandom);
    end
    return rq;
  endfunction

  // offer one request and hold it until the transaction happens
  task automatic send_request(input ucrh_pkg::in_item_t rq, input bit typed,
                              input ucrh_pkg::out_item_t want);
    ucrh_pkg::out_item_t pred;
    in_valid <= 1'b1;
    in_data <= rq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = predict_reply(rq);
    pending_replies.push_back(typed ? want : pred);
    requests_sent++;
  endtask

  task automatic idle_cycles(input int n);
    in_valid <= 1'b0;
    in_data <= rand_setup();
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // write the status register, then read it back
  task automatic write_self_powered(input logic v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ucrh_pkg::ADDR_SELF_POWERED;
    pwdata <= {31'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    self_pwr = v;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[0] !== v) begin
      protocol_errors++;
      $display("self_powered readback: expected %0b got %0h", v, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int n, input int gap_max);
    int burst;
    burst = $urandom_range(1, 16);
    repeat (n) begin
      send_request(rand_setup(), 1'b0, '0);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 16);
        if (gap_max > 0) idle_cycles($urandom_range(1, gap_max));
      end
    end
  endtask

  task automatic check_field(input string fname, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      field_mismatches++;
      if (field_mismatches <= 10)
        $display("%s mismatch at %0t: expected %0h got %0h", fname, $realtime, want, got);
    end
  endtask

  // compare each result against the oldest expectation
  always @(posedge clk) begin
    ucrh_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        protocol_errors++;
        $display("unexpected result at %0t", $realtime);
      end else begin
        want = pending_replies.pop_front();
        check_field("status", 16'(want.status), 16'(out_data.status));
        check_field("reply_length", 16'(want.reply_length), 16'(out_data.reply_length));
        check_field("reply_byte0", 16'(want.reply_byte0), 16'(out_data.reply_byte0));
        check_field("reply_byte1", 16'(want.reply_byte1), 16'(out_data.reply_byte1));
        check_field("raised_event", 16'(want.raised_event), 16'(out_data.raised_event));
        check_field("device_address", 16'(want.device_address),
                    16'(out_data.device_address));
        check_field("active_configuration", 16'(want.active_configuration),
                    16'(out_data.active_configuration));
        check_field("active_interface", 16'(want.active_interface),
                    16'(out_data.active_interface));
        check_field("active_alternate", 16'(want.active_alternate),
                    16'(out_data.active_alternate));
        check_field("desc_type", 16'(want.desc_type), 16'(out_data.desc_type));
        check_field("descriptor_index", 16'(want.descriptor_index),
                    16'(out_data.descriptor_index));
        check_field("descriptor_max_length", want.descriptor_max_length,
                    out_data.descriptor_max_length);
        replies_checked++;
        if (out_data.status == ucrh_pkg::STATUS_ACK) acks_seen++;
        else if (out_data.status == ucrh_pkg::STATUS_STALL) stalls_seen++;
        else if (out_data.status == ucrh_pkg::STATUS_FWD) forwards_seen++;
      end
    end
  end

  // result side: stall pattern per phase, plus one long hold-off on request
  initial begin
    int hold_cnt;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < 200; hold_cnt++) @(posedge clk);
        hold_off_req = 1'b0;
        out_ready <= 1'b1;
      end else begin
        sink_tick++;
        case (sink_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ((sink_tick % 11) < 6) ^ ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  // directed script, then random phases under different settings
  initial begin
    ucrh_pkg::out_item_t fwd_reply;
    fwd_reply = reply_of(ucrh_pkg::STATUS_FWD, 2'd0, 8'd0);
    fwd_reply.desc_type = 8'hff;
    fwd_reply.descriptor_index = 8'hff;
    fwd_reply.descriptor_max_length = 16'hffff;
    dev_address = '0;
    dev_config = '0;
    dev_intf = '0;
    dev_alt = '0;
    ep_halted = '0;
    self_pwr = 1'b1;

    // rows checked by hand run while the stored state is still at reset
    script_rows.push_back('{setup_of(ucrh_pkg::DEV_CREATED, 8'h80, ucrh_pkg::REQ_GET_STATUS,
                                     16'h0, 16'h0, 16'h2),
                            1'b1, reply_of(ucrh_pkg::STATUS_STALL, 2'd0, 8'd0)});
    script_rows.push_back('{setup_of(ucrh_pkg::DEV_UNKNOWN, 8'hff, 8'hff, 16'hffff, 16'hffff,
                                     16'hffff),
                            1'b1, reply_of(ucrh_pkg::STATUS_ACK, 2'd0, 8'd0)});
    script_rows.push_back('{setup_of(ucrh_pkg::DEV_POWERED, 8'h00, ucrh_pkg::REQ_SET_ADDRESS,
                                     16'h5, 16'h0, 16'h0),
                            1'b1, reply_of(ucrh_pkg::STATUS_STALL, 2'd0, 8'd0)});
    script_rows.push_back('{setup_of(ucrh_pkg::DEV_ATTACHED, 8'h00, ucrh_pkg::REQ_SET_CONFIG,
                                     16'h1, 16'h0, 16'h0),
                            1'b1, reply_of(ucrh_pkg::STATUS_STALL, 2'd0, 8'd0)});
    script_rows.push_back('{setup_of(ucrh_pkg::DEV_INIT, 8'h80, ucrh_pkg::REQ_GET_STATUS,
                                     16'h0, 16'h0, 16'h2),
                            1'b1, reply_of(ucrh_pkg::STATUS_STALL, 2'd0, 8'd0)});
    script_rows.push_back('{setup_of(ucrh_pkg::DEV_DEFAULT, 8'h82, ucrh_pkg::REQ_SYNCH_FRAME,
                                     16'h0, 16'h1, 16'h2),
                            1'b1, reply_of(ucrh_pkg::STATUS_STALL, 2'd0, 8'd0)});
    script_rows.push_back('{setup_of(ucrh_pkg::DEV_DEFAULT, 8'h00, ucrh_pkg::REQ_SET_DESCRIPTOR,
                                     16'h100, 16'h0, 16'h12),
                            1'b1, reply_of(ucrh_pkg::STATUS_STALL, 2'd0, 8'd0)});
    script_rows.push_back('{setup_of(ucrh_pkg::DEV_ADDRESSED, 8'h80, 8'hff, 16'h0, 16'h0,
                                     16'h0),
                            1'b1, reply_of(ucrh_pkg::STATUS_STALL, 2'd0, 8'd0)});
    script_rows.push_back('{setup_of(ucrh_pkg::DEV_ADDRESSED, 8'h00, ucrh_pkg::REQ_GET_CONFIG,
                                     16'h0, 16'h0, 16'h1),
                            1'b1, reply_of(ucrh_pkg::STATUS_STALL, 2'd0, 8'd0)});
    script_rows.push_back('{setup_of(ucrh_pkg::DEV_DEFAULT, 8'h00, ucrh_pkg::REQ_SET_ADDRESS,
                                     16'h80, 16'h0, 16'h0),
                            1'b1, reply_of(ucrh_pkg::STATUS_STALL, 2'd0, 8'd0)});
    script_rows.push_back('{setup_of(ucrh_pkg::DEV_ADDRESSED, 8'h00, ucrh_pkg::REQ_SET_ADDRESS,
                                     16'h10, 16'h0, 16'h0),
                            1'b1, reply_of(ucrh_pkg::STATUS_STALL, 2'd0, 8'd0)});
    script_rows.push_back('{setup_of(ucrh_pkg::DEV_CONFIGURED, 8'h02, ucrh_pkg::REQ_SET_FEATURE,
                                     16'h1, 16'h1, 16'h0),
                            1'b1, reply_of(ucrh_pkg::STATUS_STALL, 2'd0, 8'd0)});
    script_rows.push_back('{setup_of(ucrh_pkg::DEV_ADDRESSED, 8'h80,
                                     ucrh_pkg::REQ_GET_DESCRIPTOR, 16'hffff, 16'h0, 16'hffff),
                            1'b1, fwd_reply});
    script_rows.push_back('{setup_of(ucrh_pkg::DEV_CONFIGURED, 8'h80, ucrh_pkg::REQ_GET_STATUS,
                                     16'h0, 16'h0, 16'h2),
                            1'b1, reply_of(ucrh_pkg::STATUS_ACK, 2'd2, 8'd1)});
    script_rows.push_back('{setup_of(ucrh_pkg::DEV_CONFIGURED, 8'h83, ucrh_pkg::REQ_GET_STATUS,
                                     16'h0, 16'h0, 16'h2),
                            1'b1, reply_of(ucrh_pkg::STATUS_ACK, 2'd0, 8'd0)});
    script_rows.push_back('{setup_of(ucrh_pkg::DEV_CONFIGURED, 8'h9f, ucrh_pkg::REQ_GET_STATUS,
                                     16'h0, 16'h0, 16'h2),
                            1'b1, reply_of(ucrh_pkg::STATUS_ACK, 2'd2, 8'd0)});
    script_rows.push_back('{setup_of(ucrh_pkg::DEV_ADDRESSED, 8'h81, ucrh_pkg::REQ_GET_STATUS,
                                     16'h0, 16'h3, 16'h2),
                            1'b1, reply_of(ucrh_pkg::STATUS_ACK, 2'd2, 8'd0)});
    // rows that change the stored state are left to the model
    script_rows.push_back('{setup_of(ucrh_pkg::DEV_DEFAULT, 8'h00, ucrh_pkg::REQ_SET_ADDRESS,
                                     16'h7f, 16'h0, 16'h0), 1'b0, '0});
    script_rows.push_back('{setup_of(ucrh_pkg::DEV_ADDRESSED, 8'h00, ucrh_pkg::REQ_SET_CONFIG,
                                     16'hffff, 16'h0, 16'h0), 1'b0, '0});
    script_rows.push_back('{setup_of(ucrh_pkg::DEV_CONFIGURED, 8'h01,
                                     ucrh_pkg::REQ_SET_INTERFACE, 16'hffff, 16'hffff, 16'h0),
                            1'b0, '0});
    script_rows.push_back('{setup_of(ucrh_pkg::DEV_CONFIGURED, 8'h81,
                                     ucrh_pkg::REQ_GET_INTERFACE, 16'h0, 16'hff, 16'h1),
                            1'b0, '0});
    script_rows.push_back('{setup_of(ucrh_pkg::DEV_CONFIGURED, 8'h80, ucrh_pkg::REQ_GET_CONFIG,
                                     16'h0, 16'h0, 16'h1), 1'b0, '0});
    script_rows.push_back('{setup_of(ucrh_pkg::DEV_CONFIGURED, 8'h02, ucrh_pkg::REQ_SET_FEATURE,
                                     16'h0, 16'h008f, 16'h0), 1'b0, '0});
    script_rows.push_back('{setup_of(ucrh_pkg::DEV_CONFIGURED, 8'h82, ucrh_pkg::REQ_GET_STATUS,
                                     16'h0, 16'h000f, 16'h2), 1'b0, '0});
    script_rows.push_back('{setup_of(ucrh_pkg::DEV_ADDRESSED, 8'h02,
                                     ucrh_pkg::REQ_CLEAR_FEATURE, 16'h0, 16'hfff0, 16'h0),
                            1'b0, '0});
    script_rows.push_back('{setup_of(ucrh_pkg::DEV_CONFIGURED, 8'h82, ucrh_pkg::REQ_GET_STATUS,
                                     16'h0, 16'h0, 16'h2), 1'b0, '0});

    // hold the synchronous reset, then release it
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed script with the status bit at its reset value
    sink_mode = 1;
    foreach (script_rows[i]) begin
      send_request(script_rows[i].rq, script_rows[i].typed, script_rows[i].want);
      if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 3));
    end
    wait_idle();

    // back to back on both sides
    write_self_powered(1'b0);
    sink_mode = 0;
    run_random(340, 0);
    wait_idle();

    // long hold-off on the result side while requests keep coming
    write_self_powered(1'b1);
    sink_mode = 1;
    hold_off_req = 1'b1;
    run_random(340, 6);
    wait_idle();

    // bursty sender against a periodic stall pattern
    write_self_powered(1'b0);
    sink_mode = 2;
    run_random(344, 8);
    wait_idle();

    if (pending_replies.size() != 0) begin
      protocol_errors++;
      $display("%0d expected results never arrived", pending_replies.size());
    end
    $display("sent %0d setup packets, checked %0d results", requests_sent, replies_checked);
    $display("replies: %0d ack, %0d stall, %0d forwarded; %0d field mismatches",
             acks_seen, stalls_seen, forwards_seen, field_mismatches);
    if (field_mismatches == 0 && protocol_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
